// File: design/htd_pkg.sv
package htd_pkg;

    localparam int NodeDepth  = 512;
    localparam int MaxCodeLen = 16;

    localparam int NodeAw  = $clog2(NodeDepth);
    localparam int CountW  = NodeAw + 1;
    localparam int CodeW   = 16;
    localparam int LenW    = 5;
    localparam int SymW    = 8;
    localparam int ByteW   = 8;
    localparam int PadW    = 3;
    localparam int ActW    = 2;
    localparam int BitCntW = $clog2(ByteW + 1);
    localparam int CodeRegW = MaxCodeLen;
    localparam int AlignW  = $clog2(MaxCodeLen + 1);

    localparam logic [ActW-1:0] ActClear  = 2'd0;
    localparam logic [ActW-1:0] ActLoad   = 2'd1;
    localparam logic [ActW-1:0] ActDecode = 2'd2;

    typedef struct packed {
        logic                         leaf;
        logic [SymW-1:0]              sym;
        logic [1:0][NodeAw-1:0]       kid;
    } node_t;

    typedef struct packed {
        logic                         rd_en;
        logic [NodeAw-1:0]            rd_addr;
        logic                         wr_en;
        logic [NodeAw-1:0]            wr_addr;
        node_t                        wr_node;
        logic                         root_wr;
        logic [1:0][NodeAw-1:0]       root_kid;
    } store_req_t;

endpackage

// File: design/htd_if.sv
interface htd_in_if;
    logic                           valid;
    logic                           ready;
    logic [htd_pkg::ActW-1:0]       action;
    logic [htd_pkg::SymW-1:0]       symbol;
    logic [htd_pkg::CodeW-1:0]      code_bits;
    logic [htd_pkg::LenW-1:0]       code_length;
    logic [htd_pkg::ByteW-1:0]      data_byte;
    logic                           final_req;
    logic [htd_pkg::PadW-1:0]       pad_bits;

    modport source (
        output valid, action, symbol, code_bits, code_length, data_byte, final_req, pad_bits,
        input  ready
    );
    modport sink (
        input  valid, action, symbol, code_bits, code_length, data_byte, final_req, pad_bits,
        output ready
    );
endinterface

interface htd_out_if;
    logic                           valid;
    logic                           ready;
    logic [htd_pkg::SymW-1:0]       decoded_symbol;
    logic                           error;
    logic                           last;

    modport source (
        output valid, decoded_symbol, error, last,
        input  ready
    );
    modport sink (
        input  valid, decoded_symbol, error, last,
        output ready
    );
endinterface

// File: design/htd_node_store.sv
module htd_node_store (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  htd_pkg::store_req_t req,
    output htd_pkg::node_t      rd_node,
    output htd_pkg::node_t      root_node
);

    htd_pkg::node_t                     mem [htd_pkg::NodeDepth];
    htd_pkg::node_t                     rd_node_reg;
    logic [1:0][htd_pkg::NodeAw-1:0]    root_kid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_node;
        end
        if (req.rd_en)
        begin
            rd_node_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_kid_reg <= '0;
        end
        else if (clear)
        begin
            root_kid_reg <= '0;
        end
        else if (req.root_wr)
        begin
            root_kid_reg <= req.root_kid;
        end
    end

    assign rd_node   = rd_node_reg;
    assign root_node = '{leaf: 1'b0, sym: '0, kid: root_kid_reg};

endmodule

// File: design/htd_loader.sv
module htd_loader (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        clear,
    input  logic [htd_pkg::SymW-1:0]    symbol,
    input  logic [htd_pkg::CodeW-1:0]   code_bits,
    input  logic [htd_pkg::LenW-1:0]    code_length,
    input  htd_pkg::node_t              rd_node,
    input  htd_pkg::node_t              root_node,
    output htd_pkg::store_req_t         req,
    output logic                        busy
);

    typedef enum logic [2:0] {
        L_IDLE,
        L_ALIGN,
        L_WALK,
        L_END,
        L_ALLOC
    } state_t;

    state_t                             state_reg, state_next;
    logic [htd_pkg::CodeRegW-1:0]       code_reg, code_next;
    logic [htd_pkg::AlignW-1:0]         align_reg, align_next;
    logic [htd_pkg::LenW-1:0]           left_reg, left_next;
    logic [htd_pkg::CountW-1:0]         count_reg, count_next;
    logic [htd_pkg::NodeAw-1:0]         idx_reg, idx_next;
    logic                               at_root_reg, at_root_next;
    logic [htd_pkg::SymW-1:0]           sym_reg, sym_next;

    htd_pkg::node_t                     cur;
    htd_pkg::node_t                     link_node;
    htd_pkg::node_t                     new_node;
    logic                               bit_sel;
    logic [htd_pkg::NodeAw-1:0]         child;
    logic [htd_pkg::CountW-1:0]         count_inc;
    logic                               fits;
    logic                               len_ok;

    assign cur       = at_root_reg ? root_node : rd_node;
    assign bit_sel   = code_reg[htd_pkg::CodeRegW-1];
    assign child     = cur.kid[bit_sel];
    assign count_inc = count_reg + htd_pkg::CountW'(1);
    assign fits      = (int'(count_reg) + int'(left_reg)) <= htd_pkg::NodeDepth;
    assign len_ok    = (code_length != '0) && (int'(code_length) <= htd_pkg::MaxCodeLen);

    always_comb
    begin
        state_next   = state_reg;
        code_next    = code_reg;
        align_next   = align_reg;
        left_next    = left_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        at_root_next = at_root_reg;
        sym_next     = sym_reg;
        req          = '0;

        link_node = cur;
        link_node.kid[bit_sel] = count_reg[htd_pkg::NodeAw-1:0];

        new_node = '0;
        if (left_reg != '0)
        begin
            new_node.kid[bit_sel] = count_inc[htd_pkg::NodeAw-1:0];
        end
        else
        begin
            new_node.leaf = 1'b1;
            new_node.sym  = sym_reg;
        end

        unique case (state_reg)
            L_IDLE:
            begin
                if (clear)
                begin
                    count_next = htd_pkg::CountW'(1);
                end
                if (start && len_ok)
                begin
                    code_next    = htd_pkg::CodeRegW'(code_bits);
                    align_next   = htd_pkg::AlignW'(htd_pkg::MaxCodeLen - int'(code_length));
                    left_next    = code_length;
                    sym_next     = symbol;
                    at_root_next = 1'b1;
                    state_next   = L_ALIGN;
                end
            end
            L_ALIGN:
            begin
                if (align_reg == '0)
                begin
                    state_next = L_WALK;
                end
                else
                begin
                    code_next  = code_reg << 1;
                    align_next = align_reg - htd_pkg::AlignW'(1);
                end
            end
            L_WALK:
            begin
                if (cur.leaf)
                begin
                    state_next = L_IDLE;
                end
                else if (child == '0)
                begin
                    if (fits)
                    begin
                        if (at_root_reg)
                        begin
                            req.root_wr  = 1'b1;
                            req.root_kid = link_node.kid;
                        end
                        else
                        begin
                            req.wr_en   = 1'b1;
                            req.wr_addr = idx_reg;
                            req.wr_node = link_node;
                        end
                        code_next  = code_reg << 1;
                        left_next  = left_reg - htd_pkg::LenW'(1);
                        state_next = L_ALLOC;
                    end
                    else
                    begin
                        state_next = L_IDLE;
                    end
                end
                else
                begin
                    req.rd_en    = 1'b1;
                    req.rd_addr  = child;
                    idx_next     = child;
                    at_root_next = 1'b0;
                    code_next    = code_reg << 1;
                    left_next    = left_reg - htd_pkg::LenW'(1);
                    if (left_reg == htd_pkg::LenW'(1))
                    begin
                        state_next = L_END;
                    end
                end
            end
            L_END:
            begin
                if (rd_node.kid == '0)
                begin
                    req.wr_en        = 1'b1;
                    req.wr_addr      = idx_reg;
                    req.wr_node      = '0;
                    req.wr_node.leaf = 1'b1;
                    req.wr_node.sym  = sym_reg;
                end
                state_next = L_IDLE;
            end
            L_ALLOC:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = count_reg[htd_pkg::NodeAw-1:0];
                req.wr_node = new_node;
                count_next  = count_inc;
                if (left_reg != '0)
                begin
                    code_next = code_reg << 1;
                    left_next = left_reg - htd_pkg::LenW'(1);
                end
                else
                begin
                    state_next = L_IDLE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= L_IDLE;
            code_reg    <= '0;
            align_reg   <= '0;
            left_reg    <= '0;
            count_reg   <= htd_pkg::CountW'(1);
            idx_reg     <= '0;
            at_root_reg <= 1'b1;
            sym_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            code_reg    <= code_next;
            align_reg   <= align_next;
            left_reg    <= left_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            at_root_reg <= at_root_next;
            sym_reg     <= sym_next;
        end
    end

    assign busy = (state_reg != L_IDLE);

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (int'(count_reg) <= htd_pkg::NodeDepth))
        else $error("node count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == L_ALLOC) |-> (int'(count_reg) < htd_pkg::NodeDepth))
        else $error("allocation past end of node store");
`endif

endmodule

// File: design/htd_walker.sv
module htd_walker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        clear,
    input  logic [htd_pkg::ByteW-1:0]   data_byte,
    input  logic                        final_req,
    input  logic [htd_pkg::PadW-1:0]    pad_bits,
    input  htd_pkg::node_t              rd_node,
    input  htd_pkg::node_t              root_node,
    output htd_pkg::store_req_t         req,
    output logic                        busy,
    htd_out_if.source                   out_ch
);

    typedef enum logic [1:0] {
        W_IDLE,
        W_FETCH,
        W_RUN,
        W_LAST
    } state_t;

    state_t                             state_reg, state_next;
    logic [htd_pkg::ByteW-1:0]          byte_reg, byte_next;
    logic [htd_pkg::BitCntW-1:0]        bits_reg, bits_next;
    logic                               final_reg, final_next;
    logic [htd_pkg::NodeAw-1:0]         pos_reg, pos_next;
    logic                               pend_reg, pend_next;
    logic                               hold_valid_reg, hold_valid_next;
    logic [htd_pkg::SymW-1:0]           hold_sym_reg, hold_sym_next;
    logic                               hold_err_reg, hold_err_next;
    logic                               out_valid_reg, out_valid_next;
    logic [htd_pkg::SymW-1:0]           out_sym_reg, out_sym_next;
    logic                               out_err_reg, out_err_next;
    logic                               out_last_reg, out_last_next;

    htd_pkg::node_t                     cur;
    logic                               bit_sel;
    logic [htd_pkg::NodeAw-1:0]         child;
    logic                               out_free;
    logic                               emit_ok;
    logic                               emit;
    logic [htd_pkg::SymW-1:0]           emit_sym;
    logic                               emit_err;

    assign cur      = (pos_reg == '0) ? root_node : rd_node;
    assign bit_sel  = byte_reg[htd_pkg::ByteW-1];
    assign child    = cur.kid[bit_sel];
    assign out_free = !out_valid_reg || out_ch.ready;
    assign emit_ok  = !hold_valid_reg || out_free;

    always_comb
    begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        bits_next       = bits_reg;
        final_next      = final_reg;
        pos_next        = pos_reg;
        pend_next       = pend_reg;
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        hold_err_next   = hold_err_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_sym_next    = out_sym_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;
        req             = '0;
        emit            = 1'b0;
        emit_sym        = '0;
        emit_err        = 1'b0;

        unique case (state_reg)
            W_IDLE:
            begin
                if (clear)
                begin
                    pos_next = '0;
                end
                if (start)
                begin
                    byte_next  = data_byte;
                    bits_next  = final_req
                               ? htd_pkg::BitCntW'(htd_pkg::ByteW) - htd_pkg::BitCntW'(pad_bits)
                               : htd_pkg::BitCntW'(htd_pkg::ByteW);
                    final_next = final_req;
                    state_next = W_FETCH;
                end
            end
            W_FETCH:
            begin
                req.rd_en   = (pos_reg != '0);
                req.rd_addr = pos_reg;
                pend_next   = 1'b0;
                state_next  = W_RUN;
            end
            W_RUN:
            begin
                if (pend_reg && rd_node.leaf)
                begin
                    if (emit_ok)
                    begin
                        emit      = 1'b1;
                        emit_sym  = rd_node.sym;
                        pos_next  = '0;
                        pend_next = 1'b0;
                    end
                end
                else if (bits_reg == '0)
                begin
                    pend_next  = 1'b0;
                    state_next = W_LAST;
                end
                else if (child == '0)
                begin
                    if (emit_ok)
                    begin
                        emit      = 1'b1;
                        emit_err  = 1'b1;
                        pos_next  = '0;
                        pend_next = 1'b0;
                        byte_next = byte_reg << 1;
                        bits_next = bits_reg - htd_pkg::BitCntW'(1);
                    end
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = child;
                    pos_next    = child;
                    pend_next   = 1'b1;
                    byte_next   = byte_reg << 1;
                    bits_next   = bits_reg - htd_pkg::BitCntW'(1);
                end
            end
            W_LAST:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_sym_next    = hold_sym_reg;
                        out_err_next    = hold_err_reg;
                        out_last_next   = 1'b1;
                        hold_valid_next = 1'b0;
                    end
                    if (final_reg)
                    begin
                        pos_next = '0;
                    end
                    state_next = W_IDLE;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase

        // push the held word out, keep the new one until the next tells whether it is last
        if (emit)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_sym_next   = hold_sym_reg;
                out_err_next   = hold_err_reg;
                out_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_sym_next   = emit_sym;
            hold_err_next   = emit_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= W_IDLE;
            byte_reg       <= '0;
            bits_reg       <= '0;
            final_reg      <= 1'b0;
            pos_reg        <= '0;
            pend_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_sym_reg   <= '0;
            hold_err_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_sym_reg    <= '0;
            out_err_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_reg       <= byte_next;
            bits_reg       <= bits_next;
            final_reg      <= final_next;
            pos_reg        <= pos_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
            hold_sym_reg   <= hold_sym_next;
            hold_err_reg   <= hold_err_next;
            out_valid_reg  <= out_valid_next;
            out_sym_reg    <= out_sym_next;
            out_err_reg    <= out_err_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign busy                  = (state_reg != W_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.decoded_symbol = out_sym_reg;
    assign out_ch.error          = out_err_reg;
    assign out_ch.last           = out_last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == W_IDLE) |-> !hold_valid_reg)
        else $error("held word left behind after item end");

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (pos_reg != '0))
        else $error("pending node check at root");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ch.error) |-> (out_ch.decoded_symbol == '0))
        else $error("error word carries a symbol");
`endif

endmodule

// File: design/huffman_tree_decoder.sv
// Huffman tree-walk decoder. Each input word is one of: clear (tree back to an empty root),
// load (bind a symbol to a code of 1 to MaxCodeLen bits) or decode (walk one
// compressed byte MSB first, emitting one output word per symbol found or per dead-end bit,
// with last set on the final word of that byte). Input is taken only when both sequencers
// are idle; the output register lets a finished word wait while the next input is taken.
// A load aligns the code to the top of its register, walks the existing path one code bit
// at a time and then allocates one new node per remaining bit; a load with a bad length
// is ignored and stores nothing. A decode walks one bit per step and waits for each node
// read, because the node store has a single read port with registered data; it also waits
// while the output is stalled. The root lives in flip-flops, so no clearing pass runs
// after reset.
module huffman_tree_decoder (
    input  logic        clk,
    input  logic        rst_n,
    htd_in_if.sink      in_ch,
    htd_out_if.source   out_ch
);

    logic                   accept;
    logic                   clear;
    logic                   load_start;
    logic                   walk_start;
    logic                   load_busy;
    logic                   walk_busy;
    htd_pkg::store_req_t    load_req;
    htd_pkg::store_req_t    walk_req;
    htd_pkg::store_req_t    store_req;
    htd_pkg::node_t         rd_node;
    htd_pkg::node_t         root_node;

    assign in_ch.ready = !load_busy && !walk_busy;
    assign accept      = in_ch.valid && in_ch.ready;
    assign clear       = accept && (in_ch.action == htd_pkg::ActClear);
    assign load_start  = accept && (in_ch.action == htd_pkg::ActLoad);
    assign walk_start  = accept && (in_ch.action == htd_pkg::ActDecode);
    assign store_req   = load_busy ? load_req : walk_req;

    htd_node_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .req       (store_req),
        .rd_node   (rd_node),
        .root_node (root_node)
    );

    htd_loader u_loader (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (load_start),
        .clear       (clear),
        .symbol      (in_ch.symbol),
        .code_bits   (in_ch.code_bits),
        .code_length (in_ch.code_length),
        .rd_node     (rd_node),
        .root_node   (root_node),
        .req         (load_req),
        .busy        (load_busy)
    );

    htd_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (walk_start),
        .clear     (clear),
        .data_byte (in_ch.data_byte),
        .final_req (in_ch.final_req),
        .pad_bits  (in_ch.pad_bits),
        .rd_node   (rd_node),
        .root_node (root_node),
        .req       (walk_req),
        .busy      (walk_busy),
        .out_ch    (out_ch)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        !(load_busy && walk_busy))
        else $error("loader and walker active together");
`endif

endmodule
